// File: rtl/core/sts_pkg.sv
// Shared types and constants for the s-expression token scanner.
`default_nettype none

package sts_pkg;

    // Default magnitude width of the number accumulator
    localparam int NUM_WIDTH_DEF = 32;

    // Width of the number field on the result port
    localparam int VALUE_W = 32;

    // Most results one text byte can cause
    localparam int MAX_RES = 3;

    // Character codes the scanner recognises
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;

    // Token kinds on the result port
    typedef enum logic [3:0] {
        K_LPAREN  = 4'd0,
        K_RPAREN  = 4'd1,
        K_NUMBER  = 4'd2,
        K_STRCHAR = 4'd3,
        K_STREND  = 4'd4,
        K_IDCHAR  = 4'd5,
        K_IDEND   = 4'd6,
        K_EOT     = 4'd7,
        K_UNTERM  = 4'd8
    } t_kind;

    // Scanner mode, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_MINUS  = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_STRING = 5'b01000,
        MODE_IDENT  = 5'b10000
    } t_mode;

    // One result item
    typedef struct packed {
        t_kind                      kind;
        logic signed [VALUE_W-1:0]  value;
        logic [7:0]                 chr;
    } t_result;

    // All results caused by one text byte, slot 0 first
    typedef struct packed {
        logic [1:0]               count;
        t_result [MAX_RES-1:0]    res;
    } t_run;

endpackage

`default_nettype wire

// File: rtl/core/sts_decode.sv
// Per-byte decode: next scanner state and the run of results for one byte.
`default_nettype none

module sts_decode #(
    parameter int NUM_WIDTH = sts_pkg::NUM_WIDTH_DEF
) (
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_eot,
    input  wire sts_pkg::t_mode        i_mode,
    input  wire logic [NUM_WIDTH-1:0]  i_mag,
    input  wire logic                  i_neg,
    output sts_pkg::t_mode             o_mode,
    output logic [NUM_WIDTH-1:0]       o_mag,
    output logic                       o_neg,
    output sts_pkg::t_run              o_run
);

    function automatic sts_pkg::t_result mk(input sts_pkg::t_kind kind,
                                            input logic [7:0] chr);
        sts_pkg::t_result r;
        r.kind  = kind;
        r.value = '0;
        r.chr   = chr;
        return r;
    endfunction

    logic                          is_blank;
    logic                          is_digit;
    logic [NUM_WIDTH-1:0]          digit;
    logic signed [NUM_WIDTH-1:0]   num_v;
    sts_pkg::t_result              num_res;
    logic [NUM_WIDTH-1:0]          mag_x10;

    // Start-of-token decode, used from idle and after a number ends
    logic                          st_hit;
    sts_pkg::t_result              st_res;
    sts_pkg::t_mode                st_mode;

    // Byte classes
    assign is_blank = (i_byte == sts_pkg::CH_SPACE) || (i_byte == sts_pkg::CH_TAB) ||
                      (i_byte == sts_pkg::CH_NL);
    assign is_digit = (i_byte >= sts_pkg::CH_ZERO) && (i_byte <= sts_pkg::CH_NINE);
    assign digit    = NUM_WIDTH'(i_byte[3:0]);

    // Accumulate: magnitude * 10 as two shifts and an add
    assign mag_x10 = (i_mag << 3) + (i_mag << 1);

    // Finished number, negated when a minus led it, sign-extended or cut to 32 bits
    assign num_v = i_neg ? signed'(~i_mag + NUM_WIDTH'(1)) : signed'(i_mag);
    always_comb begin
        num_res.kind  = sts_pkg::K_NUMBER;
        num_res.value = sts_pkg::VALUE_W'(num_v);
        num_res.chr   = '0;
    end

    // Token start
    always_comb begin
        st_hit  = 1'b0;
        st_res  = mk(sts_pkg::K_LPAREN, '0);
        st_mode = sts_pkg::MODE_IDLE;
        priority if (is_blank) begin
            st_mode = sts_pkg::MODE_IDLE;
        end else if (i_byte == sts_pkg::CH_LPAREN) begin
            st_hit = 1'b1;
            st_res = mk(sts_pkg::K_LPAREN, '0);
        end else if (i_byte == sts_pkg::CH_RPAREN) begin
            st_hit = 1'b1;
            st_res = mk(sts_pkg::K_RPAREN, '0);
        end else if (i_byte == sts_pkg::CH_QUOTE) begin
            st_mode = sts_pkg::MODE_STRING;
        end else if (is_digit) begin
            st_mode = sts_pkg::MODE_NUMBER;
        end else if (i_byte == sts_pkg::CH_MINUS) begin
            st_mode = sts_pkg::MODE_MINUS;
        end else begin
            st_hit  = 1'b1;
            st_res  = mk(sts_pkg::K_IDCHAR, i_byte);
            st_mode = sts_pkg::MODE_IDENT;
        end
    end

    // Main decode
    always_comb begin
        o_mode       = i_mode;
        o_mag        = i_mag;
        o_neg        = i_neg;
        o_run.count  = 2'd0;
        o_run.res[0] = mk(sts_pkg::K_LPAREN, '0);
        o_run.res[1] = mk(sts_pkg::K_LPAREN, '0);
        o_run.res[2] = mk(sts_pkg::K_LPAREN, '0);

        if (i_eot) begin
            // End of text flushes whatever token is open
            o_mode = sts_pkg::MODE_IDLE;
            o_mag  = '0;
            o_neg  = 1'b0;
            unique case (i_mode)
                sts_pkg::MODE_MINUS: begin
                    o_run.res[0] = mk(sts_pkg::K_IDCHAR, sts_pkg::CH_MINUS);
                    o_run.res[1] = mk(sts_pkg::K_IDEND, '0);
                    o_run.res[2] = mk(sts_pkg::K_EOT, '0);
                    o_run.count  = 2'd3;
                end
                sts_pkg::MODE_NUMBER: begin
                    o_run.res[0] = num_res;
                    o_run.res[1] = mk(sts_pkg::K_EOT, '0);
                    o_run.count  = 2'd2;
                end
                sts_pkg::MODE_STRING: begin
                    o_run.res[0] = mk(sts_pkg::K_UNTERM, '0);
                    o_run.count  = 2'd1;
                end
                sts_pkg::MODE_IDENT: begin
                    o_run.res[0] = mk(sts_pkg::K_IDEND, '0);
                    o_run.res[1] = mk(sts_pkg::K_EOT, '0);
                    o_run.count  = 2'd2;
                end
                default: begin
                    o_run.res[0] = mk(sts_pkg::K_EOT, '0);
                    o_run.count  = 2'd1;
                end
            endcase
        end else begin
            unique case (i_mode)
                sts_pkg::MODE_MINUS: begin
                    if (is_digit) begin
                        o_mag  = digit;
                        o_neg  = 1'b1;
                        o_mode = sts_pkg::MODE_NUMBER;
                    end else begin
                        // Lone minus becomes an identifier
                        o_run.res[0] = mk(sts_pkg::K_IDCHAR, sts_pkg::CH_MINUS);
                        o_run.count  = 2'd2;
                        if (is_blank) begin
                            o_run.res[1] = mk(sts_pkg::K_IDEND, '0);
                            o_mode       = sts_pkg::MODE_IDLE;
                        end else begin
                            o_run.res[1] = mk(sts_pkg::K_IDCHAR, i_byte);
                            o_mode       = sts_pkg::MODE_IDENT;
                        end
                    end
                end
                sts_pkg::MODE_NUMBER: begin
                    if (is_digit) begin
                        o_mag = mag_x10 + digit;
                    end else begin
                        // Number ends; this byte starts the next token
                        o_run.res[0] = num_res;
                        o_run.res[1] = st_res;
                        o_run.count  = st_hit ? 2'd2 : 2'd1;
                        o_mag        = '0;
                        o_neg        = 1'b0;
                        o_mode       = st_mode;
                    end
                end
                sts_pkg::MODE_STRING: begin
                    o_run.count = 2'd1;
                    if (i_byte == sts_pkg::CH_QUOTE) begin
                        o_run.res[0] = mk(sts_pkg::K_STREND, '0);
                        o_mode       = sts_pkg::MODE_IDLE;
                    end else begin
                        o_run.res[0] = mk(sts_pkg::K_STRCHAR, i_byte);
                    end
                end
                sts_pkg::MODE_IDENT: begin
                    o_run.count = 2'd1;
                    if (is_blank) begin
                        o_run.res[0] = mk(sts_pkg::K_IDEND, '0);
                        o_mode       = sts_pkg::MODE_IDLE;
                    end else begin
                        o_run.res[0] = mk(sts_pkg::K_IDCHAR, i_byte);
                    end
                end
                default: begin
                    o_run.res[0] = st_res;
                    o_run.count  = st_hit ? 2'd1 : 2'd0;
                    o_mode       = st_mode;
                    if (is_digit) begin
                        o_mag = digit;
                        o_neg = 1'b0;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sexpr_token_scanner_top.sv
// A byte is held in the input register; its results then load into the result queue.
// Input takes one byte per cycle while the result port is ready; a byte causing two or
// three results holds input ready low while the result queue drains.
// The limit is the three-slot result queue, refilled only as its last entry leaves.
// Reset (synchronous, active low) empties both stages and returns the scanner to idle.
`default_nettype none

module sexpr_token_scanner_top #(
    parameter int NUM_WIDTH = sts_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_end_of_input,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [3:0]                o_token_kind,
    output logic signed [31:0]        o_number_value,
    output logic [7:0]                o_char_byte,
    output logic                      o_last_of_run
);

    // Input register
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_eot;

    // Scanner state
    sts_pkg::t_mode        r_mode;
    sts_pkg::t_mode        n_mode;
    logic [NUM_WIDTH-1:0]  r_mag;
    logic [NUM_WIDTH-1:0]  n_mag;
    logic                  r_neg;
    logic                  n_neg;

    // Result queue
    sts_pkg::t_result [sts_pkg::MAX_RES-1:0] r_q;
    sts_pkg::t_result [sts_pkg::MAX_RES-1:0] n_q;
    logic [1:0]            r_count;
    logic [1:0]            n_count;

    sts_pkg::t_run         run;
    logic                  pop;
    logic                  q_free;
    logic                  advance;

    sts_decode #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_decode (
        .i_byte (r_in_byte),
        .i_eot  (r_in_eot),
        .i_mode (r_mode),
        .i_mag  (r_mag),
        .i_neg  (r_neg),
        .o_mode (n_mode),
        .o_mag  (n_mag),
        .o_neg  (n_neg),
        .o_run  (run)
    );

    // Handshake: the queue takes a new run once its last entry leaves
    assign pop        = o_out_valid && i_out_ready;
    assign q_free     = (r_count == 2'd0) || ((r_count == 2'd1) && pop);
    assign advance    = r_in_valid && q_free;
    assign o_in_ready = !r_in_valid || q_free;

    // Input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_eot  <= i_end_of_input;
        end
    end

    // Scanner state update on each byte leaving the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sts_pkg::MODE_IDLE;
            r_mag  <= '0;
            r_neg  <= 1'b0;
        end else if (advance) begin
            r_mode <= n_mode;
            r_mag  <= n_mag;
            r_neg  <= n_neg;
        end
    end

    // Queue next value: load a whole run, or shift one out
    always_comb begin
        n_q     = r_q;
        n_count = r_count;
        if (advance) begin
            n_q     = run.res;
            n_count = run.count;
        end else if (pop) begin
            n_q[0]  = r_q[1];
            n_q[1]  = r_q[2];
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // Result port
    assign o_out_valid    = (r_count != 2'd0);
    assign o_token_kind   = r_q[0].kind;
    assign o_number_value = r_q[0].value;
    assign o_char_byte    = r_q[0].chr;
    assign o_last_of_run  = (r_count == 2'd1);

`ifndef SYNTH
    // Magnitude is only ever non-zero while a number is open
    a_mag_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != sts_pkg::MODE_NUMBER) |-> (r_mag == '0))
        else $error("magnitude left over outside a number");

    // Sign flag only set inside a number
    a_neg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != sts_pkg::MODE_NUMBER) |-> !r_neg)
        else $error("sign flag left over outside a number");

    // Input stalls only while results are pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_count != 2'd0))
        else $error("input stalled with empty result queue");

    // End of text always leaves the scanner idle
    a_eot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_eot) |=> (r_mode == sts_pkg::MODE_IDLE))
        else $error("scanner not idle after end of text");

    // A loaded run is never empty on the port when a result was decoded
    a_run_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (run.count != 2'd0)) |=> o_out_valid)
        else $error("decoded results lost");
`endif

endmodule

`default_nettype wire
